// File: src/dnr_pkg.sv
// ----------------------------------------------------------------------------
// dnr_pkg: shared types and constants for decimal narrowing
// Field structs, controller/datapath command and status groups, status codes
// and the constants of the limb-serial divide-by-ten.
// ----------------------------------------------------------------------------
package dnr_pkg;

  localparam int WIDE_BITS   = 256;
  localparam int NARROW_BITS = 96;
  localparam int MAX_SCALE   = 28;

  // The mantissa is divided by ten one limb per cycle, most significant first.
  localparam int LIMB_W     = 32;
  localparam int LIMBS      = WIDE_BITS / LIMB_W;
  localparam int LIMB_CNT_W = $clog2(LIMBS);

  // floor(2^35 / 10): the quotient estimate of a 36-bit partial dividend is
  // low by at most one, and a single correction step fixes it.
  localparam int               DIV_SHIFT = 35;
  localparam logic [LIMB_W-1:0] RECIP10  = 32'd3435973836;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_POS_OVF = 2'd1;
  localparam logic [1:0] ST_NEG_OVF = 2'd2;

  typedef struct packed {
    logic [63:0] mant_word0;
    logic [63:0] mant_word1;
    logic [63:0] mant_word2;
    logic [63:0] mant_word3;
    logic [5:0]  scale_in;
    logic        negative;
  } in_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [31:0] result_high;
    logic [4:0]  scale_out;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic load;
    logic start_drop;
    logic div_step;
    logic round_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic too_wide;
    logic scale_zero;
    logic scale_over;
  } sts_t;

endpackage

// File: src/dnr_datapath.sv
// ----------------------------------------------------------------------------
// dnr_datapath: mantissa register, limb-serial divide by ten and rounding
// Holds the working mantissa and scale, divides by ten one limb per cycle by
// rotating the mantissa, rounds half to even and forms the result register.
// ----------------------------------------------------------------------------
module dnr_datapath (
  input  logic          clk_i,
  input  dnr_pkg::in_t  in_data_i,
  input  dnr_pkg::cmd_t cmd_i,
  output dnr_pkg::sts_t sts_o,
  output dnr_pkg::out_t out_data_o
);

  localparam int CUR_W  = dnr_pkg::LIMB_W + 4;
  localparam int PROD_W = CUR_W + dnr_pkg::LIMB_W;

  logic [dnr_pkg::WIDE_BITS-1:0] mant_q, mant_d;
  logic [5:0]                    scale_q, scale_d;
  logic                          neg_q, neg_d;
  logic                          rounded_q, rounded_d;
  logic [3:0]                    rem_q, rem_d;
  dnr_pkg::out_t                 out_q, out_d;

  logic [CUR_W-1:0]           cur;
  logic [PROD_W-1:0]          prod;
  logic [dnr_pkg::LIMB_W-1:0] q_est, q_fix;
  logic [CUR_W-1:0]           r_est, ten_q;
  logic [3:0]                 r_fix;
  logic                       round_up;
  logic                       mant_zero;
  logic [255:0]               in_mant;

  assign in_mant = {in_data_i.mant_word3, in_data_i.mant_word2,
                    in_data_i.mant_word1, in_data_i.mant_word0};

  // Partial dividend: previous remainder above the current top limb.
  assign cur   = {rem_q, mant_q[dnr_pkg::WIDE_BITS-1 -: dnr_pkg::LIMB_W]};
  assign prod  = PROD_W'(cur) * PROD_W'(dnr_pkg::RECIP10);
  assign q_est = prod[dnr_pkg::DIV_SHIFT +: dnr_pkg::LIMB_W];
  assign ten_q = (CUR_W'(q_est) << 3) + (CUR_W'(q_est) << 1);
  assign r_est = cur - ten_q;

  always_comb begin
    if (r_est >= CUR_W'(10)) begin
      q_fix = q_est + dnr_pkg::LIMB_W'(1);
      r_fix = 4'(r_est - CUR_W'(10));
    end else begin
      q_fix = q_est;
      r_fix = r_est[3:0];
    end
  end

  // After a full pass mant_q is the quotient and rem_q the dropped digit.
  assign round_up  = (rem_q > 4'd5) || ((rem_q == 4'd5) && mant_q[0]);
  assign mant_zero = (mant_q == '0);

  assign sts_o.too_wide   = |mant_q[dnr_pkg::WIDE_BITS-1:dnr_pkg::NARROW_BITS];
  assign sts_o.scale_zero = (scale_q == 6'd0);
  assign sts_o.scale_over = (scale_q > 6'(dnr_pkg::MAX_SCALE));

  always_comb begin
    mant_d    = mant_q;
    scale_d   = scale_q;
    neg_d     = neg_q;
    rounded_d = rounded_q;
    rem_d     = rem_q;
    out_d     = out_q;
    if (cmd_i.load) begin
      mant_d    = in_mant[dnr_pkg::WIDE_BITS-1:0];
      scale_d   = in_data_i.scale_in;
      neg_d     = in_data_i.negative;
      rounded_d = 1'b0;
    end
    if (cmd_i.start_drop) begin
      scale_d   = scale_q - 6'd1;
      rounded_d = 1'b1;
      rem_d     = 4'd0;
    end
    if (cmd_i.div_step) begin
      mant_d = {mant_q[dnr_pkg::WIDE_BITS-dnr_pkg::LIMB_W-1:0], q_fix};
      rem_d  = r_fix;
    end
    if (cmd_i.round_step) begin
      mant_d = mant_q + dnr_pkg::WIDE_BITS'(round_up);
    end
    if (cmd_i.finish) begin
      out_d = '0;
      if (sts_o.too_wide) begin
        out_d.status = neg_q ? dnr_pkg::ST_NEG_OVF : dnr_pkg::ST_POS_OVF;
      end else if (rounded_q && mant_zero) begin
        out_d.status = dnr_pkg::ST_NEG_OVF;
      end else begin
        out_d.result_low  = mant_q[63:0];
        out_d.result_high = mant_q[95:64];
        out_d.scale_out   = scale_q[4:0];
        out_d.status      = dnr_pkg::ST_OK;
      end
    end
  end

  // Payload registers only; sequencing lives in the controller.
  always_ff @(posedge clk_i) begin
    mant_q    <= mant_d;
    scale_q   <= scale_d;
    neg_q     <= neg_d;
    rounded_q <= rounded_d;
    rem_q     <= rem_d;
    out_q     <= out_d;
  end

  assign out_data_o = out_q;

endmodule

// File: src/dnr_ctrl.sv
// ----------------------------------------------------------------------------
// dnr_ctrl: sequencer for decimal narrowing
// Runs check, eight limb divide steps and a rounding step per dropped digit,
// and owns the input stall and the output valid flag.
// ----------------------------------------------------------------------------
module dnr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  dnr_pkg::sts_t sts_i,
  output dnr_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_ROUND = 2'd3;

  localparam logic [dnr_pkg::LIMB_CNT_W-1:0] LAST_LIMB =
    dnr_pkg::LIMB_CNT_W'(dnr_pkg::LIMBS - 1);

  logic [1:0]                      state_q, state_d;
  logic [dnr_pkg::LIMB_CNT_W-1:0] cnt_q, cnt_d;
  logic                            out_vld_q, out_vld_d;
  logic                            out_free;
  logic                            need_drop;

  assign out_free  = !out_vld_q || !out_stall_i;
  assign need_drop = (sts_i.too_wide && !sts_i.scale_zero) ||
                     (!sts_i.too_wide && sts_i.scale_over);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    out_vld_d = out_vld_q && out_stall_i;
    cmd_o     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (need_drop) begin
          cmd_o.start_drop = 1'b1;
          cnt_d            = '0;
          state_d          = S_DIV;
        end else if (out_free) begin
          // The result waits here until the output register can take it.
          cmd_o.finish = 1'b1;
          out_vld_d    = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + dnr_pkg::LIMB_CNT_W'(1);
        if (cnt_q == LAST_LIMB) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd_o.round_step = 1'b1;
        state_d          = S_CHECK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// File: src/decimal_narrow_with_bank_round_top.sv
// ----------------------------------------------------------------------------
// decimal_narrow_with_bank_round_top: narrow a wide decimal mantissa
// Drops decimal digits with round half to even until the mantissa fits in
// 96 bits and the scale is at most 28; flags overflow and rounding to zero.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i, in_stall_o, in_data_i) takes a 256-bit
// mantissa, a scale and a sign; the output channel (out_valid_o, out_stall_i,
// out_data_o) returns one result per input transfer, in order.
// One item is in work at a time. After the input transfer the item is
// loaded; each dropped digit then takes a check, eight limb steps of the
// 32-bit divide-by-ten unit and one rounding increment, and a last check
// writes the output register. At most sixty-three digits are dropped, and
// that per-limb divide unit sets the rate.
// The output register lets a new item be accepted and worked on while the
// previous result waits; a finished result then holds in the datapath until
// the output register is free.
// Reset clears the sequencer and the output valid flag; no state carries
// from one item to the next.
// ----------------------------------------------------------------------------
module decimal_narrow_with_bank_round_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dnr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dnr_pkg::out_t out_data_o
);

  dnr_pkg::cmd_t cmd;
  dnr_pkg::sts_t sts;

  dnr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dnr_datapath u_datapath (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

`ifndef ASSERT_OFF
  // An accepted item keeps the input side busy while it is worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transfer");

  // Any error status comes with cleared result fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != dnr_pkg::ST_OK) |->
      (out_data_o.result_low == '0) && (out_data_o.result_high == '0) &&
      (out_data_o.scale_out == '0))
    else $error("error status with nonzero result");

  // A good result never carries a scale above the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == dnr_pkg::ST_OK) |->
      (out_data_o.scale_out <= 5'(dnr_pkg::MAX_SCALE)))
    else $error("result scale above limit");
`endif

endmodule

// File: dv/narrow_checker.sv
// ----------------------------------------------------------------------------
// narrow_checker: result prediction and comparison for decimal narrowing
// Watches both channels of the block. Every input transfer is narrowed here
// by repeated divide-by-ten with round half to even, and each output transfer
// is compared field by field with the oldest narrowed value still waiting.
// ----------------------------------------------------------------------------
module narrow_checker
  import dnr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  out_t        narrowed_q[$];
  int unsigned fails;

  // One decimal digit off the mantissa; a dropped five goes to the even neighbor.
  function automatic logic [255:0] div10_half_even(input logic [255:0] mant);
    logic [255:0] quot;
    logic [255:0] digit;
    quot  = mant / 256'd10;
    digit = mant % 256'd10;
    if (digit > 256'd5 || (digit == 256'd5 && quot[0])) begin
      quot = quot + 256'd1;
    end
    return quot;
  endfunction

  function automatic out_t narrow_item(input in_t item);
    logic [255:0] mant;
    int unsigned  scl;
    logic         dropped;
    out_t         res;
    mant    = {item.mant_word3, item.mant_word2, item.mant_word1, item.mant_word0};
    scl     = item.scale_in;
    dropped = 1'b0;
    res     = '0;
    // A rounding carry can push the mantissa back over the limit, so the
    // width is tested again after every drop.
    while (|(mant >> NARROW_BITS)) begin
      if (scl == 0) begin
        res.status = item.negative ? ST_NEG_OVF : ST_POS_OVF;
        return res;
      end
      scl--;
      mant    = div10_half_even(mant);
      dropped = 1'b1;
    end
    while (scl > MAX_SCALE) begin
      mant    = div10_half_even(mant);
      scl--;
      dropped = 1'b1;
    end
    // Rounding away to nothing shares the code of negative overflow.
    if (dropped && mant == '0) begin
      res.status = ST_NEG_OVF;
      return res;
    end
    res.result_low  = mant[63:0];
    res.result_high = mant[95:64];
    res.scale_out   = 5'(scl);
    res.status      = ST_OK;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t want;
    logic bad;
    if (!rst_ni) begin
      narrowed_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (narrowed_q.size() == 0) begin
          if (fails < 10) begin
            $display("unexpected output transfer: low %h high %h scale %0d status %0d",
                     out_data_i.result_low, out_data_i.result_high,
                     out_data_i.scale_out, out_data_i.status);
          end
          fails++;
        end else begin
          want = narrowed_q.pop_front();
          bad  = (out_data_i.result_low !== want.result_low) ||
                 (out_data_i.result_high !== want.result_high) ||
                 (out_data_i.scale_out !== want.scale_out) ||
                 (out_data_i.status !== want.status);
          if (bad) begin
            if (fails < 10) begin
              $display("mismatch at %0t (expected / actual):", $realtime);
              $display("  low    %h / %h", want.result_low, out_data_i.result_low);
              $display("  high   %h / %h", want.result_high, out_data_i.result_high);
              $display("  scale  %0d / %0d", want.scale_out, out_data_i.scale_out);
              $display("  status %0d / %0d", want.status, out_data_i.status);
            end
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        narrowed_q.push_back(narrow_item(in_data_i));
      end
      pending_o <= narrowed_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for decimal_narrow_with_bank_round_top
// Drives directed corner values (overflow, rounding ties, rounding to zero,
// carries back over the width limit) and then random mantissas of mixed
// widths and scales, with random idle cycles on both channels, one long
// receiver hold-off and drain pauses. Checking is done by narrow_checker.
// ----------------------------------------------------------------------------
module testbench;
  import dnr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned  RANDOM_ITEMS = 1650;
  localparam int unsigned  HOLD_CYCLES  = 1500;
  localparam int unsigned  TAIL_CYCLES  = 700;
  localparam int unsigned  STUCK_LIMIT  = 20000;
  localparam logic [255:0] NARROW_LIMIT = 256'd1 << NARROW_BITS;
  localparam logic [255:0] ALL_ONES     = {256{1'b1}};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned stuck_cycles = 0;
  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;

  decimal_narrow_with_bank_round_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  narrow_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic in_t make_item(input logic [255:0] mant, input logic [5:0] scl,
                                    input logic neg);
    in_t item;
    item.mant_word0 = mant[63:0];
    item.mant_word1 = mant[127:64];
    item.mant_word2 = mant[191:128];
    item.mant_word3 = mant[255:192];
    item.scale_in   = scl;
    item.negative   = neg;
    return item;
  endfunction

  // Random mantissa below 2^bits, with the top bit forced half of the time.
  function automatic logic [255:0] random_mantissa(input int unsigned bits);
    logic [255:0] mant;
    mant = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    mant = mant & ((256'd1 << bits) - 256'd1);
    if ($urandom_range(1) == 1) begin
      mant[bits-1] = 1'b1;
    end
    return mant;
  endfunction

  function automatic in_t random_item();
    logic [255:0] mant;
    logic [5:0]   scl;
    logic         neg;
    int unsigned  pick;
    pick = $urandom_range(99);
    neg  = 1'($urandom_range(1));
    if (pick < 35) begin
      mant = random_mantissa($urandom_range(1, 110));
      scl  = 6'($urandom_range(0, 34));
    end else if (pick < 50) begin
      // Small values one to three digits above the scale limit; many ties.
      mant = 256'($urandom_range(0, 999) * 10 +
                  (($urandom_range(2) == 0) ? 5 : $urandom_range(0, 9)));
      scl  = 6'($urandom_range(29, 31));
    end else if (pick < 60) begin
      mant = 256'($urandom_range(0, 60));
      scl  = 6'($urandom_range(29, 63));
    end else if (pick < 70) begin
      // Around the width limit, where a rounding carry can overflow again.
      mant = (($urandom_range(1) == 1) ? NARROW_LIMIT : NARROW_LIMIT * 256'd10) - 256'd12 +
             256'($urandom_range(0, 24));
      scl  = 6'($urandom_range(0, 3));
    end else if (pick < 85) begin
      mant = random_mantissa($urandom_range(97, 256));
      scl  = 6'($urandom);
    end else begin
      mant = random_mantissa(256);
      scl  = 6'($urandom);
    end
    return make_item(mant, scl, neg);
  endfunction

  // Returns at the clock edge of the transfer, valid still high.
  task automatic offer(input in_t item);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, none in calm stretches, and one long hold-off.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 16);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero with and without rounding, width limit, overflow of either sign.
    offer(make_item('0, 6'd0, 1'b0));
    offer(make_item('0, 6'd63, 1'b1));
    offer(make_item(NARROW_LIMIT - 256'd1, 6'd28, 1'b0));
    offer(make_item(NARROW_LIMIT - 256'd1, 6'd0, 1'b1));
    offer(make_item(NARROW_LIMIT - 256'd1, 6'd29, 1'b0));
    offer(make_item(NARROW_LIMIT, 6'd0, 1'b0));
    offer(make_item(NARROW_LIMIT, 6'd0, 1'b1));
    offer(make_item(NARROW_LIMIT, 6'd1, 1'b0));
    offer(make_item(ALL_ONES, 6'd63, 1'b0));
    offer(make_item(ALL_ONES, 6'd0, 1'b1));
    offer(make_item(ALL_ONES, 6'd47, 1'b0));
    offer(make_item(ALL_ONES, 6'd49, 1'b1));
    offer(make_item(256'd1 << 255, 6'd63, 1'b1));
    // Ties go to even, other digits to nearest.
    offer(make_item(256'd25, 6'd29, 1'b0));
    offer(make_item(256'd35, 6'd29, 1'b1));
    offer(make_item(256'd15, 6'd29, 1'b0));
    offer(make_item(256'd26, 6'd29, 1'b0));
    offer(make_item(256'd24, 6'd29, 1'b0));
    // Rounded away to zero, and a single digit that survives.
    offer(make_item(256'd5, 6'd29, 1'b0));
    offer(make_item(256'd4, 6'd29, 1'b1));
    offer(make_item(256'd6, 6'd29, 1'b0));
    offer(make_item(256'd1, 6'd63, 1'b0));
    // The rounding carry lands exactly on the width limit.
    offer(make_item(NARROW_LIMIT * 256'd10 - 256'd1, 6'd1, 1'b0));
    offer(make_item(NARROW_LIMIT * 256'd10 - 256'd1, 6'd2, 1'b1));
    offer(make_item(256'd123, 6'd28, 1'b1));
    drain();

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 300 && i < 700);
      if (i == 320) begin
        hold_req = 1'b1;
      end
      if (i == 1000) begin
        drain();
      end
      offer(random_item());
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
